[hdl/twrq_pkg.sv]
// ----------------------------------------------------------------------------
// twrq_pkg
// Shared types, codes and helpers for the transmit window retransmit queue.
// ----------------------------------------------------------------------------
package twrq_pkg;

  localparam int unsigned WINDOW_SLOTS = 256;
  localparam int unsigned SLOT_W       = $clog2(WINDOW_SLOTS);

  // item function codes
  localparam logic [2:0] FUNC_ADD    = 3'd0;
  localparam logic [2:0] FUNC_REQ    = 3'd1;
  localparam logic [2:0] FUNC_PEEK   = 3'd2;
  localparam logic [2:0] FUNC_REMOVE = 3'd3;
  localparam logic [2:0] FUNC_LOOKUP = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_REJECT   = 2'd1;
  localparam logic [1:0] STAT_Q_EMPTY  = 2'd2;
  localparam logic [1:0] STAT_W_EMPTY  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_EXEC,
    ST_LINK2,
    ST_FINISH
  } state_e;

  // per-slot packet data and retransmit bookkeeping
  typedef struct packed {
    logic [15:0] len;
    logic [31:0] ck;
    logic        waiting;
    logic [7:0]  req;
    logic [7:0]  sent;
  } slot_t;

  // queue links: nxt toward tail (older), prv toward head (newer)
  typedef struct packed {
    logic [SLOT_W-1:0] nxt;
    logic [SLOT_W-1:0] prv;
  } link_t;

  // serial-number window membership
  function automatic logic in_window(input logic [31:0] s, input logic [31:0] lead,
                                     input logic [31:0] trail);
    logic [31:0] a;
    logic [31:0] b;
    a = s - trail;
    b = lead - s;
    in_window = ((lead + 32'd1) != trail) && !a[31] && !b[31];
  endfunction

endpackage

[hdl/twrq_in_if.sv]
// ----------------------------------------------------------------------------
// twrq_in_if
// Request channel: valid/ready handshake with one request item.
// ----------------------------------------------------------------------------
interface twrq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [31:0] sequence_req;
  logic        parity_req;
  logic [15:0] payload_length;
  logic [31:0] packet_checksum;

  modport source (output valid, func, sequence_req, parity_req, payload_length,
                  packet_checksum, input ready);
  modport sink (input valid, func, sequence_req, parity_req, payload_length,
                packet_checksum, output ready);
endinterface

[hdl/twrq_out_if.sv]
// ----------------------------------------------------------------------------
// twrq_out_if
// Result channel: valid/ready handshake with one result item.
// ----------------------------------------------------------------------------
interface twrq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] out_sequence;
  logic [15:0] out_length;
  logic [31:0] out_checksum;
  logic        out_parity;
  logic [7:0]  parity_offset;
  logic [23:0] window_bytes;
  logic [8:0]  window_fill;

  modport source (output valid, status, out_sequence, out_length, out_checksum,
                  out_parity, parity_offset, window_bytes, window_fill,
                  input ready);
  modport sink (input valid, status, out_sequence, out_length, out_checksum,
                out_parity, parity_offset, window_bytes, window_fill,
                output ready);
endinterface

[hdl/transmit_window_retransmit_queue_top.sv]
// ----------------------------------------------------------------------------
// transmit_window_retransmit_queue_top
// Ring transmit window over serial sequence numbers with a fifo retransmit
// queue kept as a doubly linked list in a slot memory.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  in_i      in    valid/ready    func, sequence_req, parity_req, length, checksum
//  out_o     out   valid/ready    status, sequence, length, checksum, parity, fill
//  cfg       in    cfg_we_i       parity_group_shift (3 bits)
//
//  an item steps through issue, a slot/link memory read and modify (exec), an
//  extra link write when a queue entry is spliced out or pushed, then the result register.
//  the single write port of the link memory makes that second link write its own step.
//  reset empties window and queue; the memories need no clearing.
//  a held result stalls the finish step; a new item is taken only once back in idle.
module transmit_window_retransmit_queue_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_data_i,
  twrq_in_if.sink    in_i,
  twrq_out_if.source out_o
);

  localparam int unsigned SW = twrq_pkg::SLOT_W;

  twrq_pkg::state_e state_q, state_d;

  // captured item
  logic [2:0]  func_q, func_d;
  logic [31:0] seq_q, seq_d;
  logic        par_q, par_d;
  logic [15:0] len_q, len_d;
  logic [31:0] ck_q, ck_d;
  logic [SW-1:0] x_q, x_d;

  // window and queue state
  logic [2:0]  shift_q;
  logic [31:0] lead_q, lead_d;
  logic [31:0] trail_q, trail_d;
  logic [23:0] bytes_q, bytes_d;
  logic        qe_q, qe_d;
  logic [SW-1:0] qh_q, qh_d;
  logic [SW-1:0] qt_q, qt_d;

  // second link write
  logic [SW-1:0] l2_addr_q, l2_addr_d;
  logic [SW-1:0] l2_data_q, l2_data_d;
  logic          l2_prv_q, l2_prv_d;
  logic          l2_head_q, l2_head_d;

  // result under construction
  logic [1:0]  rs_status_q, rs_status_d;
  logic [31:0] rs_seq_q, rs_seq_d;
  logic [15:0] rs_len_q, rs_len_d;
  logic [31:0] rs_ck_q, rs_ck_d;
  logic        rs_par_q, rs_par_d;
  logic [7:0]  rs_off_q, rs_off_d;

  // output register
  logic        ov_q;
  logic        out_load;
  logic [1:0]  o_status_q;
  logic [31:0] o_seq_q;
  logic [15:0] o_len_q;
  logic [31:0] o_ck_q;
  logic        o_par_q;
  logic [7:0]  o_off_q;
  logic [23:0] o_bytes_q;
  logic [8:0]  o_fill_q;

  // memories
  twrq_pkg::slot_t slot_mem [twrq_pkg::WINDOW_SLOTS];
  twrq_pkg::link_t link_mem [twrq_pkg::WINDOW_SLOTS];
  twrq_pkg::slot_t slot_rd_q, sl_wd;
  twrq_pkg::link_t link_rd_q;
  logic [SW-1:0] rd_addr, sl_wa, lk_wa, lk_wd;
  logic          sl_we, lk_we, lk_prv;

  logic [31:0] fill32;
  assign fill32 = lead_q - trail_q + 32'd1;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 3'd0;
    end else if (cfg_we_i) begin
      shift_q <= cfg_data_i;
    end
  end

  // slot and link memories, registered read
  always_ff @(posedge clk_i) begin
    if (sl_we) begin
      slot_mem[sl_wa] <= sl_wd;
    end
    if (lk_we) begin
      if (lk_prv) begin
        link_mem[lk_wa].prv <= lk_wd;
      end else begin
        link_mem[lk_wa].nxt <= lk_wd;
      end
    end
    slot_rd_q <= slot_mem[rd_addr];
    link_rd_q <= link_mem[rd_addr];
  end

  // next state and datapath
  always_comb begin
    logic        empty;
    logic [31:0] mask;
    logic [31:0] tgt;
    logic [7:0]  cnt;
    logic [7:0]  sent1;
    logic [31:0] nlead;
    logic        unlink_go;
    logic        push_go;
    logic [SW-1:0] tail_ofs;

    state_d = state_q;
    func_d = func_q; seq_d = seq_q; par_d = par_q; len_d = len_q; ck_d = ck_q;
    x_d = x_q;
    lead_d = lead_q; trail_d = trail_q; bytes_d = bytes_q;
    qe_d = qe_q; qh_d = qh_q; qt_d = qt_q;
    l2_addr_d = l2_addr_q; l2_data_d = l2_data_q;
    l2_prv_d = l2_prv_q; l2_head_d = l2_head_q;
    rs_status_d = rs_status_q; rs_seq_d = rs_seq_q; rs_len_d = rs_len_q;
    rs_ck_d = rs_ck_q; rs_par_d = rs_par_q; rs_off_d = rs_off_q;
    sl_we = 1'b0; sl_wa = x_q; sl_wd = slot_rd_q;
    lk_we = 1'b0; lk_wa = x_q; lk_wd = x_q; lk_prv = 1'b0;
    out_load = 1'b0;
    unlink_go = 1'b0;
    push_go = 1'b0;

    empty = (lead_q + 32'd1) == trail_q;
    mask  = 32'hffff_ffff << shift_q;
    tgt   = par_q ? (seq_q & mask) : seq_q;
    cnt   = seq_q[7:0] & ~mask[7:0];
    nlead = lead_q + 32'd1;
    sent1 = slot_rd_q.sent + 8'd1;
    tail_ofs = x_q - trail_q[SW-1:0];

    unique case (state_q)
      twrq_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          func_d = in_i.func; seq_d = in_i.sequence_req; par_d = in_i.parity_req;
          len_d = in_i.payload_length; ck_d = in_i.packet_checksum;
          state_d = twrq_pkg::ST_ISSUE;
        end
      end

      // early outcomes and slot read
      twrq_pkg::ST_ISSUE: begin
        rs_status_d = twrq_pkg::STAT_OK; rs_seq_d = '0; rs_len_d = '0;
        rs_ck_d = '0; rs_par_d = 1'b0; rs_off_d = '0;
        state_d = twrq_pkg::ST_FINISH;
        priority case (func_q)
          twrq_pkg::FUNC_ADD: begin
            if (!empty && fill32 >= 32'(twrq_pkg::WINDOW_SLOTS)) begin
              x_d = trail_q[SW-1:0];
              state_d = twrq_pkg::ST_EXEC;
            end else begin
              sl_we = 1'b1;
              sl_wa = nlead[SW-1:0];
              sl_wd = '{len: len_q, ck: ck_q, waiting: 1'b0, req: 8'd0, sent: 8'd0};
              lead_d = nlead;
              bytes_d = bytes_q + {8'd0, len_q};
              rs_seq_d = nlead; rs_len_d = len_q; rs_ck_d = ck_q;
            end
          end
          twrq_pkg::FUNC_REQ: begin
            if (empty) begin
              rs_status_d = twrq_pkg::STAT_W_EMPTY;
            end else if (!twrq_pkg::in_window(tgt, lead_q, trail_q)) begin
              rs_status_d = twrq_pkg::STAT_REJECT;
            end else begin
              x_d = tgt[SW-1:0];
              state_d = twrq_pkg::ST_EXEC;
            end
          end
          twrq_pkg::FUNC_PEEK, twrq_pkg::FUNC_REMOVE: begin
            if (qe_q) begin
              rs_status_d = twrq_pkg::STAT_Q_EMPTY;
            end else begin
              x_d = qt_q;
              state_d = twrq_pkg::ST_EXEC;
            end
          end
          twrq_pkg::FUNC_LOOKUP: begin
            if (empty) begin
              rs_status_d = twrq_pkg::STAT_W_EMPTY;
            end else if (!twrq_pkg::in_window(seq_q, lead_q, trail_q)) begin
              rs_status_d = twrq_pkg::STAT_REJECT;
            end else begin
              x_d = seq_q[SW-1:0];
              state_d = twrq_pkg::ST_EXEC;
            end
          end
          default: begin
          end
        endcase
      end

      // slot data valid: modify, write back, start list update
      twrq_pkg::ST_EXEC: begin
        state_d = twrq_pkg::ST_FINISH;
        priority case (func_q)
          twrq_pkg::FUNC_ADD: begin
            bytes_d = bytes_q - {8'd0, slot_rd_q.len} + {8'd0, len_q};
            trail_d = trail_q + 32'd1;
            lead_d = nlead;
            sl_we = 1'b1;
            sl_wd = '{len: len_q, ck: ck_q, waiting: 1'b0, req: 8'd0, sent: 8'd0};
            rs_seq_d = nlead; rs_len_d = len_q; rs_ck_d = ck_q;
            unlink_go = slot_rd_q.waiting;
          end
          twrq_pkg::FUNC_REQ: begin
            if (slot_rd_q.waiting) begin
              rs_status_d = twrq_pkg::STAT_REJECT;
              if (par_q && slot_rd_q.req < cnt) begin
                sl_we = 1'b1;
                sl_wd.req = cnt;
              end
            end else begin
              sl_we = 1'b1;
              sl_wd.waiting = 1'b1;
              if (par_q) begin
                sl_wd.req = slot_rd_q.req + 8'd1;
              end
              push_go = 1'b1;
            end
          end
          twrq_pkg::FUNC_PEEK, twrq_pkg::FUNC_REMOVE: begin
            rs_seq_d = trail_q + {{(32-SW){1'b0}}, tail_ofs};
            rs_len_d = slot_rd_q.len;
            rs_ck_d = slot_rd_q.ck;
            rs_par_d = slot_rd_q.req != 8'd0;
            rs_off_d = (slot_rd_q.req != 8'd0) ? slot_rd_q.sent : 8'd0;
            if (func_q == twrq_pkg::FUNC_REMOVE) begin
              sl_we = 1'b1;
              if (slot_rd_q.req != 8'd0) begin
                sl_wd.sent = sent1;
                if (sent1 == slot_rd_q.req) begin
                  sl_wd.waiting = 1'b0;
                  unlink_go = 1'b1;
                end
              end else begin
                sl_wd.waiting = 1'b0;
                unlink_go = 1'b1;
              end
            end
          end
          default: begin
            rs_seq_d = seq_q; rs_len_d = slot_rd_q.len; rs_ck_d = slot_rd_q.ck;
          end
        endcase

        // queue list update
        if (unlink_go) begin
          if (x_q == qh_q && x_q == qt_q) begin
            qe_d = 1'b1; qh_d = '0; qt_d = '0;
          end else if (x_q == qh_q) begin
            qh_d = link_rd_q.nxt;
          end else if (x_q == qt_q) begin
            qt_d = link_rd_q.prv;
          end else begin
            lk_we = 1'b1; lk_prv = 1'b0;
            lk_wa = link_rd_q.prv; lk_wd = link_rd_q.nxt;
            l2_addr_d = link_rd_q.nxt; l2_data_d = link_rd_q.prv;
            l2_prv_d = 1'b1; l2_head_d = 1'b0;
            state_d = twrq_pkg::ST_LINK2;
          end
        end else if (push_go) begin
          if (qe_q) begin
            qe_d = 1'b0; qh_d = x_q; qt_d = x_q;
          end else begin
            lk_we = 1'b1; lk_prv = 1'b1;
            lk_wa = qh_q; lk_wd = x_q;
            l2_addr_d = x_q; l2_data_d = qh_q;
            l2_prv_d = 1'b0; l2_head_d = 1'b1;
            state_d = twrq_pkg::ST_LINK2;
          end
        end
      end

      // second link write of a splice or push
      twrq_pkg::ST_LINK2: begin
        lk_we = 1'b1; lk_prv = l2_prv_q; lk_wa = l2_addr_q; lk_wd = l2_data_q;
        if (l2_head_q) begin
          qh_d = l2_addr_q;
        end
        state_d = twrq_pkg::ST_FINISH;
      end

      twrq_pkg::ST_FINISH: begin
        if (!ov_q || out_o.ready) begin
          out_load = 1'b1;
          state_d = twrq_pkg::ST_IDLE;
        end
      end

      default: state_d = twrq_pkg::ST_IDLE;
    endcase

    rd_addr = x_d;
  end

  assign in_i.ready = (state_q == twrq_pkg::ST_IDLE);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= twrq_pkg::ST_IDLE;
      lead_q  <= 32'hffff_ffff;
      trail_q <= 32'd0;
      bytes_q <= 24'd0;
      qe_q    <= 1'b1;
      qh_q    <= '0;
      qt_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      lead_q  <= lead_d;
      trail_q <= trail_d;
      bytes_q <= bytes_d;
      qe_q    <= qe_d;
      qh_q    <= qh_d;
      qt_q    <= qt_d;
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    func_q <= func_d; seq_q <= seq_d; par_q <= par_d; len_q <= len_d; ck_q <= ck_d;
    x_q <= x_d;
    l2_addr_q <= l2_addr_d; l2_data_q <= l2_data_d;
    l2_prv_q <= l2_prv_d; l2_head_q <= l2_head_d;
    rs_status_q <= rs_status_d; rs_seq_q <= rs_seq_d; rs_len_q <= rs_len_d;
    rs_ck_q <= rs_ck_d; rs_par_q <= rs_par_d; rs_off_q <= rs_off_d;
    if (out_load) begin
      o_status_q <= rs_status_q;
      o_seq_q    <= rs_seq_q;
      o_len_q    <= rs_len_q;
      o_ck_q     <= rs_ck_q;
      o_par_q    <= rs_par_q;
      o_off_q    <= rs_off_q;
      o_bytes_q  <= bytes_q;
      o_fill_q   <= fill32[8:0];
    end
  end

  assign out_o.valid         = ov_q;
  assign out_o.status        = o_status_q;
  assign out_o.out_sequence  = o_seq_q;
  assign out_o.out_length    = o_len_q;
  assign out_o.out_checksum  = o_ck_q;
  assign out_o.out_parity    = o_par_q;
  assign out_o.parity_offset = o_off_q;
  assign out_o.window_bytes  = o_bytes_q;
  assign out_o.window_fill   = o_fill_q;

  // empty queue keeps head and tail at zero
  a_qe_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qe_q |-> (qh_q == '0 && qt_q == '0)) else $error("queue ends not cleared");

  // window never holds more than the ring size
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill32 <= 32'(twrq_pkg::WINDOW_SLOTS)) else $error("window overfilled");

  // an accepted item goes to issue next
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> state_q == twrq_pkg::ST_ISSUE)
    else $error("accepted item not issued");

  // a result appears only from the finish step
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(state_q == twrq_pkg::ST_FINISH))
    else $error("result outside finish");

endmodule
